/* rtl/core/sfr_pkg.sv */
`timescale 1ns / 1ps

package sfr_pkg;

   typedef enum logic [1:0] {
      PH_WAIT  = 2'd0,
      PH_FRAME = 2'd1,
      PH_DRAIN = 2'd2
   } phase_type;

   // Input word kinds carried on req_tuser.
   localparam logic [1:0] OP_BYTE    = 2'd0;
   localparam logic [1:0] OP_IDLE    = 2'd1;
   localparam logic [1:0] OP_TIMEOUT = 2'd2;

   // Result kinds carried on rsp_tuser.
   localparam logic [2:0] KIND_PAYLOAD    = 3'd0;
   localparam logic [2:0] KIND_CONTROL_OK = 3'd1;
   localparam logic [2:0] KIND_DATA_OK    = 3'd2;
   localparam logic [2:0] KIND_REJECTED   = 3'd3;
   localparam logic [2:0] KIND_GAVE_UP    = 3'd4;
   localparam logic [2:0] KIND_TIMEOUT    = 3'd5;

   // Configuration register indexes.
   localparam logic [2:0] REG_DATA_TYPE = 3'd0;
   localparam logic [2:0] REG_CTRL_TYPE = 3'd1;
   localparam logic [2:0] REG_ACK       = 3'd2;
   localparam logic [2:0] REG_NACK      = 3'd3;
   localparam logic [2:0] REG_POLY      = 3'd4;
   localparam logic [2:0] REG_MAX_TRIES = 3'd5;

   localparam logic [7:0] MIN_DATA_LEN  = 8'd5;
   localparam logic [7:0] FIRST_PAYLOAD = 8'd4;

   typedef struct packed {
      logic [7:0] data_type_code;
      logic [7:0] control_type_code;
      logic [7:0] ack_code;
      logic [7:0] nack_code;
      logic [7:0] crc_poly;
      logic [7:0] max_tries;
   } cfg_type;

   typedef struct packed {
      logic       hit;
      logic [2:0] kind;
      logic [7:0] data;
      logic [7:0] payload_len;
      logic       reply_valid;
      logic [7:0] reply_byte;
   } result_type;

   // CRC-8, MSB first, one byte per call.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                              input logic [7:0] b,
                                              input logic [7:0] poly);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ poly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* rtl/core/sfr_cfg_regs.sv */
`timescale 1ns / 1ps

module sfr_cfg_regs (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [7:0]            csr_data,
   output sfr_pkg::cfg_type      cfg
);

   sfr_pkg::cfg_type cfg_ff;
   sfr_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            sfr_pkg::REG_DATA_TYPE: cfg_in.data_type_code    = csr_data;
            sfr_pkg::REG_CTRL_TYPE: cfg_in.control_type_code = csr_data;
            sfr_pkg::REG_ACK:       cfg_in.ack_code          = csr_data;
            sfr_pkg::REG_NACK:      cfg_in.nack_code         = csr_data;
            sfr_pkg::REG_POLY:      cfg_in.crc_poly          = csr_data;
            sfr_pkg::REG_MAX_TRIES: cfg_in.max_tries         = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.data_type_code    <= 8'd1;
         cfg_ff.control_type_code <= 8'd2;
         cfg_ff.ack_code          <= 8'd1;
         cfg_ff.nack_code         <= 8'd254;
         cfg_ff.crc_poly          <= 8'd7;
         cfg_ff.max_tries         <= 8'd3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/core/sfr_deframer.sv */
`timescale 1ns / 1ps

module sfr_deframer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [1:0]            op,
   input  logic [7:0]            rx_byte,
   input  sfr_pkg::cfg_type      cfg,
   output sfr_pkg::result_type   res
);

   sfr_pkg::phase_type phase_ff, phase_in;
   logic [7:0] byte_count_ff, byte_count_in;
   logic       is_data_ff, is_data_in;
   logic [7:0] len_ff, len_in;
   logic       match_ff, match_in;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] rej_ff, rej_in;

   logic [7:0] crc_first;
   logic [7:0] crc_next;
   logic [7:0] len_new;
   logic       match_new;
   logic [8:0] rej_next;
   logic       give_up;
   logic       do_reject;
   logic       do_accept;
   logic       do_clear;
   logic [2:0] acc_kind;
   logic [7:0] acc_data;
   logic [7:0] acc_len;

   assign crc_first = sfr_pkg::crc8_update(8'd0, rx_byte, cfg.crc_poly);
   assign crc_next  = sfr_pkg::crc8_update(crc_ff, rx_byte, cfg.crc_poly);
   assign len_new   = (byte_count_ff == 8'd1) ? rx_byte : len_ff;
   assign match_new = ((byte_count_ff == 8'd2 || byte_count_ff == 8'd3) &&
                       rx_byte != len_ff) ? 1'b0 : match_ff;
   assign rej_next  = {1'b0, rej_ff} + 9'd1;
   assign give_up   = rej_next >= {1'b0, cfg.max_tries};

   always_comb begin
      phase_in      = phase_ff;
      byte_count_in = byte_count_ff;
      is_data_in    = is_data_ff;
      len_in        = len_ff;
      match_in      = match_ff;
      crc_in        = crc_ff;
      rej_in        = rej_ff;
      res           = '0;
      do_reject     = 1'b0;
      do_accept     = 1'b0;
      do_clear      = 1'b0;
      acc_kind      = sfr_pkg::KIND_CONTROL_OK;
      acc_data      = 8'd0;
      acc_len       = 8'd0;

      case (op)
         sfr_pkg::OP_IDLE: begin
            if (phase_ff == sfr_pkg::PH_DRAIN) begin
               phase_in = sfr_pkg::PH_WAIT;
               do_clear = 1'b1;
            end
         end
         sfr_pkg::OP_TIMEOUT: begin
            if (phase_ff != sfr_pkg::PH_DRAIN) begin
               phase_in = sfr_pkg::PH_WAIT;
               rej_in   = 8'd0;
               do_clear = 1'b1;
               res.hit  = 1'b1;
               res.kind = sfr_pkg::KIND_TIMEOUT;
            end
         end
         sfr_pkg::OP_BYTE: begin
            if (phase_ff == sfr_pkg::PH_FRAME) begin
               if (!is_data_ff) begin
                  if (byte_count_ff >= sfr_pkg::FIRST_PAYLOAD) begin
                     if (match_new && rx_byte == crc_ff) begin
                        do_accept = 1'b1;
                        acc_kind  = sfr_pkg::KIND_CONTROL_OK;
                        acc_data  = len_ff;
                     end else begin
                        do_reject = 1'b1;
                     end
                  end else begin
                     len_in        = len_new;
                     match_in      = match_new;
                     crc_in        = crc_next;
                     byte_count_in = byte_count_ff + 8'd1;
                  end
               end else if (byte_count_ff == 8'd3 &&
                            (!match_new || len_new < sfr_pkg::MIN_DATA_LEN)) begin
                  do_reject = 1'b1;
               end else if (byte_count_ff >= sfr_pkg::FIRST_PAYLOAD &&
                            ({1'b0, byte_count_ff} + 9'd1) >= {1'b0, len_ff}) begin
                  if (rx_byte == crc_ff) begin
                     do_accept = 1'b1;
                     acc_kind  = sfr_pkg::KIND_DATA_OK;
                     acc_len   = len_ff - sfr_pkg::MIN_DATA_LEN;
                  end else begin
                     do_reject = 1'b1;
                  end
               end else begin
                  len_in        = len_new;
                  match_in      = match_new;
                  crc_in        = crc_next;
                  byte_count_in = byte_count_ff + 8'd1;
                  if (byte_count_ff >= sfr_pkg::FIRST_PAYLOAD) begin
                     res.hit  = 1'b1;
                     res.kind = sfr_pkg::KIND_PAYLOAD;
                     res.data = rx_byte;
                  end
               end
            end else if (phase_ff != sfr_pkg::PH_DRAIN) begin
               // Waiting for a type byte; a shared code counts as control.
               if (rx_byte == cfg.control_type_code ||
                   rx_byte == cfg.data_type_code) begin
                  phase_in      = sfr_pkg::PH_FRAME;
                  is_data_in    = (rx_byte != cfg.control_type_code);
                  byte_count_in = 8'd1;
                  len_in        = 8'd0;
                  match_in      = 1'b1;
                  crc_in        = crc_first;
               end else begin
                  do_reject = 1'b1;
               end
            end
         end
         default: ;
      endcase

      if (do_reject) begin
         phase_in        = sfr_pkg::PH_DRAIN;
         do_clear        = 1'b1;
         rej_in          = give_up ? 8'd0 : rej_next[7:0];
         res.hit         = 1'b1;
         res.kind        = give_up ? sfr_pkg::KIND_GAVE_UP : sfr_pkg::KIND_REJECTED;
         res.reply_valid = 1'b1;
         res.reply_byte  = cfg.nack_code;
      end
      if (do_accept) begin
         phase_in        = sfr_pkg::PH_WAIT;
         do_clear        = 1'b1;
         rej_in          = 8'd0;
         res.hit         = 1'b1;
         res.kind        = acc_kind;
         res.data        = acc_data;
         res.payload_len = acc_len;
         res.reply_valid = 1'b1;
         res.reply_byte  = cfg.ack_code;
      end
      if (do_clear) begin
         byte_count_in = 8'd0;
         is_data_in    = 1'b0;
         len_in        = 8'd0;
         match_in      = 1'b1;
         crc_in        = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= sfr_pkg::PH_WAIT;
         byte_count_ff <= 8'd0;
         is_data_ff    <= 1'b0;
         len_ff        <= 8'd0;
         match_ff      <= 1'b1;
         crc_ff        <= 8'd0;
         rej_ff        <= 8'd0;
      end else if (step) begin
         phase_ff      <= phase_in;
         byte_count_ff <= byte_count_in;
         is_data_ff    <= is_data_in;
         len_ff        <= len_in;
         match_ff      <= match_in;
         crc_ff        <= crc_in;
         rej_ff        <= rej_in;
      end
   end

   a_timeout_restarts: assert property (@(posedge clock) disable iff (reset)
      step && op == sfr_pkg::OP_TIMEOUT && phase_ff != sfr_pkg::PH_DRAIN
      |=> phase_ff == sfr_pkg::PH_WAIT && rej_ff == 8'd0)
      else $error("timeout did not restart the receiver");

   a_give_up_drains: assert property (@(posedge clock) disable iff (reset)
      step && res.hit && res.kind == sfr_pkg::KIND_GAVE_UP
      |=> phase_ff == sfr_pkg::PH_DRAIN && rej_ff == 8'd0)
      else $error("give-up did not drain with a cleared reject count");

   a_wait_is_clean: assert property (@(posedge clock) disable iff (reset)
      phase_ff == sfr_pkg::PH_WAIT |-> byte_count_ff == 8'd0 && match_ff)
      else $error("frame state not cleared while waiting for a type byte");

endmodule

/* rtl/core/serial_frame_receiver_crc8.sv */
`timescale 1ns / 1ps
// A result word, if its input word yields one, appears on rsp in the cycle after the input
// word is accepted. One input word per cycle while no result word is stalled; the CRC byte
// update and the frame checks sit between the frame state registers and the result register.
// A held result stalls req only while rsp_tready is low.
// Reset is synchronous and active high; it loads the register defaults and
// clears the frame state at once, with no clearing pass.

module serial_frame_receiver_crc8 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [1:0]  req_tuser,   // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] data, [15:8] payload_len,
                                    // [16] reply_valid, [24:17] reply_byte
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);

   sfr_pkg::cfg_type    cfg;
   sfr_pkg::result_type res;
   sfr_pkg::result_type out_ff, out_in;
   logic                valid_ff, valid_in;
   logic                step;

   assign req_tready = !valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;

   sfr_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sfr_deframer u_deframer (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .op      (req_tuser),
      .rx_byte (req_tdata),
      .cfg     (cfg),
      .res     (res)
   );

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      out_in   = out_ff;
      if (step) begin
         valid_in = res.hit;
         out_in   = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tdata  = {7'd0, out_ff.reply_byte, out_ff.reply_valid,
                        out_ff.payload_len, out_ff.data};

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while a result word is stalled");

   a_payload_no_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == sfr_pkg::KIND_PAYLOAD |-> !rsp_tdata[16])
      else $error("payload word carries a reply request");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");

endmodule
